// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge, reset excluded.
`define CHK_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== rtl/dvrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dvrt_pkg;
  localparam int MAX_NODES_DEF = 8;
  localparam int INFINITE_COST_DEF = 65535;
  localparam int COST_W = 16;
  localparam int IDX_W = 3;

  localparam logic [2:0] REQ_LOAD = 3'd0;
  localparam logic [2:0] REQ_VEC = 3'd1;
  localparam logic [2:0] REQ_COST = 3'd2;
  localparam logic [2:0] REQ_DOWN = 3'd3;
  localparam logic [2:0] REQ_DUMP = 3'd4;

  localparam logic CFG_MY_INDEX = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic       latch;     // capture request
    logic       apply;     // perform single-entry update
    logic       bld_wr;    // write matrix entry during build (row, col)
    logic       rc_clr;    // clear accumulator for new destination
    logic       rc_rd;     // issue matrix read for (j, i)
    logic       rc_acc;    // fold read data into accumulator
    logic       rc_wr;     // write result of destination i
    logic       dp_rd;     // issue dump read for row k
    logic       ack;       // emit acknowledgement
    logic       row;       // emit dump row
    logic       set_ready;
    logic [2:0] ci;        // outer index
    logic [2:0] cj;        // inner index
    logic       lastr;
  } dvrt_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       ready;
    logic       ok;        // latched request takes effect
    logic       do_build;
    logic       do_rc;
    logic       is_dump;
    logic [3:0] n;
    logic [2:0] me;
  } dvrt_sts_t;
endpackage
`default_nettype wire

// ===== rtl/distance_vector_route_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Distance-vector route table. Assert start while busy is low; the request
// is taken on that edge. Results come out one beat per out_valid pulse and
// cannot be stalled, so the receiver must take every beat. A request that
// recomputes walks each destination against each neighbour through the
// single matrix read port (n = effective node count), plus n*n build writes
// for the final load, and is acknowledged after the walk. Other requests
// are acknowledged from decode, except a dump: once the table is built it
// gives n rows, each in two steps (read the own matrix row, then register
// the beat), else an acknowledgement.
module distance_vector_route_table_core #(
  parameter int MAX_NODES = dvrt_pkg::MAX_NODES_DEF,
  parameter int INFINITE_COST = dvrt_pkg::INFINITE_COST_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  in_req_type,
  input  wire  [2:0]  in_node_index,
  input  wire  [2:0]  in_dest_index,
  input  wire  [15:0] in_link_cost,
  input  wire         in_last,
  output logic        out_valid,
  output logic [2:0]  out_route_dest,
  output logic [2:0]  out_next_hop,
  output logic        out_has_next_hop,
  output logic [15:0] out_path_cost,
  output logic        out_accepted,
  output logic        out_last_result,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [3:0]  cfg_data
);
  dvrt_pkg::dvrt_cmd_t cmd;
  dvrt_pkg::dvrt_sts_t sts;

  // sequencer: decode, build sweep, recompute walk, dump rows
  dvrt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  // tables, matrix memory and min-accumulator
  dvrt_dp #(.MAX_NODES(MAX_NODES), .INFINITE_COST(INFINITE_COST)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_req_type(in_req_type), .in_node_index(in_node_index),
    .in_dest_index(in_dest_index), .in_link_cost(in_link_cost), .in_last(in_last),
    .cmd(cmd), .sts(sts), .out_valid(out_valid), .out_route_dest(out_route_dest),
    .out_next_hop(out_next_hop), .out_has_next_hop(out_has_next_hop),
    .out_path_cost(out_path_cost), .out_accepted(out_accepted),
    .out_last_result(out_last_result)
  );
endmodule
`default_nettype wire

// ===== rtl/dvrt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dvrt_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  dvrt_pkg::dvrt_sts_t sts,
  output dvrt_pkg::dvrt_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC = 3'd1;
  localparam logic [2:0] S_BLD = 3'd2;
  localparam logic [2:0] S_RC = 3'd3;
  localparam logic [2:0] S_RCW = 3'd4;
  localparam logic [2:0] S_DUMP = 3'd5;
  localparam logic [2:0] S_ROW = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] i_r, i_nxt, j_r, j_nxt;
  logic       pend_r, pend_nxt;   // read in flight
  logic [3:0] n1;

  assign busy = (state_r != S_IDLE);
  assign n1 = sts.n - 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r <= '0;
      j_r <= '0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    pend_nxt = 1'b0;
    cmd = '0;
    cmd.ci = i_r;
    cmd.cj = j_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        i_nxt = '0;
        j_nxt = '0;
        if (sts.is_dump) begin
          state_nxt = S_DUMP;
        end else begin
          cmd.apply = 1'b1;
          if (sts.ok && sts.do_build) state_nxt = S_BLD;
          else if (sts.ok && sts.do_rc) state_nxt = S_RC;
          else begin
            cmd.ack = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_BLD: begin
        cmd.bld_wr = 1'b1;
        if ({1'b0, j_r} == n1) begin
          j_nxt = '0;
          if ({1'b0, i_r} == n1) begin
            i_nxt = '0;
            state_nxt = S_RC;
          end else i_nxt = i_r + 3'd1;
        end else j_nxt = j_r + 3'd1;
      end
      S_RC: begin
        // one matrix read per cycle; accumulate in the cycle after the read
        if (j_r == '0 && !pend_r) cmd.rc_clr = 1'b1;
        if (pend_r) cmd.rc_acc = 1'b1;
        if (i_r == sts.me) begin
          if ({1'b0, i_r} == n1) begin
            cmd.ack = 1'b1;
            cmd.set_ready = 1'b1;
            state_nxt = S_IDLE;
          end else i_nxt = i_r + 3'd1;
        end else begin
          cmd.rc_rd = 1'b1;
          pend_nxt = 1'b1;
          cmd.cj = j_r;
          if ({1'b0, j_r} == n1) state_nxt = S_RCW;
          else j_nxt = j_r + 3'd1;
        end
        if (pend_r) begin
          cmd.rc_clr = 1'b0;
        end
      end
      S_RCW: begin
        cmd.rc_acc = 1'b1;
        cmd.rc_wr = 1'b1;
        j_nxt = '0;
        if ({1'b0, i_r} == n1) begin
          cmd.ack = 1'b1;
          cmd.set_ready = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + 3'd1;
          state_nxt = S_RC;
        end
      end
      S_DUMP: begin
        if (!sts.ready) begin
          cmd.ack = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.dp_rd = 1'b1;
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        cmd.row = 1'b1;
        cmd.lastr = ({1'b0, i_r} == n1);
        if ({1'b0, i_r} == n1) state_nxt = S_IDLE;
        else begin
          i_nxt = i_r + 3'd1;
          state_nxt = S_DUMP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/dvrt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dvrt_dp #(
  parameter int MAX_NODES = dvrt_pkg::MAX_NODES_DEF,
  parameter int INFINITE_COST = dvrt_pkg::INFINITE_COST_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire  [0:0]          cfg_index,
  input  wire  [3:0]          cfg_data,
  input  wire  [2:0]          in_req_type,
  input  wire  [2:0]          in_node_index,
  input  wire  [2:0]          in_dest_index,
  input  wire  [15:0]         in_link_cost,
  input  wire                 in_last,
  input  dvrt_pkg::dvrt_cmd_t cmd,
  output dvrt_pkg::dvrt_sts_t sts,
  output logic                out_valid,
  output logic [2:0]          out_route_dest,
  output logic [2:0]          out_next_hop,
  output logic                out_has_next_hop,
  output logic [15:0]         out_path_cost,
  output logic                out_accepted,
  output logic                out_last_result
);
  localparam int NN = (MAX_NODES < 8) ? MAX_NODES : 8;
  localparam logic [15:0] INF = 16'(INFINITE_COST);

  logic [15:0] dm_mem [0:63];
  logic [15:0] nc_r [0:7];
  logic [7:0]  nf_r, rv_r;
  logic [2:0]  nh_r [0:7];
  logic        ready_r;
  logic [2:0]  my_r;
  logic [3:0]  cnt_r;
  logic [2:0]  typ_r, node_r, dest_r;
  logic [15:0] cost_r;
  logic        last_r;
  logic [3:0]  n;
  logic [2:0]  me;
  logic        ok;
  logic [15:0] rd_r;
  logic [2:0]  rdj_r;
  logic [16:0] best_r, sum;
  logic [2:0]  hop_r;
  logic        found_r;
  logic [5:0]  waddr, raddr;
  logic [15:0] wdata;
  logic        we;
  logic        cnt_hi;

  assign cnt_hi = (cnt_r > 4'(NN));
  assign n = (cnt_r == 4'd0) ? 4'd1 : (cnt_hi ? 4'(NN) : cnt_r);
  assign me = ({1'b0, my_r} >= n) ? 3'(n - 4'd1) : my_r;

  always_comb begin
    ok = 1'b0;
    if ({1'b0, node_r} < n) begin
      unique case (typ_r)
        dvrt_pkg::REQ_LOAD: ok = !ready_r;
        dvrt_pkg::REQ_VEC: ok = ready_r && ({1'b0, dest_r} < n);
        dvrt_pkg::REQ_COST, dvrt_pkg::REQ_DOWN: ok = ready_r;
        default: ok = 1'b0;
      endcase
    end
  end

  assign sts.ready = ready_r;
  assign sts.ok = ok;
  assign sts.do_build = (typ_r == dvrt_pkg::REQ_LOAD) && last_r;
  assign sts.do_rc = ((typ_r == dvrt_pkg::REQ_VEC) && last_r) ||
                     (typ_r == dvrt_pkg::REQ_COST) || (typ_r == dvrt_pkg::REQ_DOWN);
  assign sts.is_dump = (typ_r == dvrt_pkg::REQ_DUMP);
  assign sts.n = n;
  assign sts.me = me;

  // matrix write port
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.apply && ok && typ_r == dvrt_pkg::REQ_VEC) begin
      we = 1'b1;
      waddr = {node_r, dest_r};
      wdata = cost_r;
    end else if (cmd.apply && ok && typ_r == dvrt_pkg::REQ_COST) begin
      we = 1'b1;
      waddr = {me, node_r};
      wdata = cost_r;
    end else if (cmd.bld_wr) begin
      we = 1'b1;
      waddr = {cmd.ci, cmd.cj};
      if (cmd.ci == me) wdata = nc_r[cmd.cj];
      else if (cmd.ci == cmd.cj) wdata = '0;
      else wdata = INF;
    end else if (cmd.rc_wr) begin
      // last neighbour folds in on the write cycle
      we = 1'b1;
      waddr = {me, cmd.ci};
      wdata = (nf_r[rdj_r] && (sum < best_r)) ? sum[15:0] : best_r[15:0];
    end
  end

  assign raddr = cmd.dp_rd ? {me, cmd.ci} : {cmd.cj, cmd.ci};

  always_ff @(posedge clk) begin
    if (we) dm_mem[waddr] <= wdata;
    rd_r <= dm_mem[raddr];
    rdj_r <= cmd.cj;
  end

  assign sum = {1'b0, nc_r[rdj_r]} + {1'b0, rd_r};

  function automatic logic found_nxt_f();
    found_nxt_f = found_r || (nf_r[rdj_r] && (sum < best_r));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r <= '0;
      rv_r <= '0;
      ready_r <= 1'b0;
      my_r <= '0;
      cnt_r <= 4'd1;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.ack || cmd.row;
      if (cfg_we) begin
        unique case (cfg_index)
          dvrt_pkg::CFG_MY_INDEX: my_r <= cfg_data[2:0];
          dvrt_pkg::CFG_NODE_COUNT: cnt_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.set_ready) ready_r <= 1'b1;
      if (cmd.apply && ok && typ_r == dvrt_pkg::REQ_LOAD) begin
        nf_r[node_r] <= (cost_r != 16'd0) && (cost_r < INF);
        rv_r[node_r] <= (cost_r < INF);
      end
      if (cmd.apply && ok && typ_r == dvrt_pkg::REQ_DOWN) nf_r[node_r] <= 1'b0;
      if (cmd.rc_wr) rv_r[cmd.ci] <= found_nxt_f() || nf_r[cmd.ci];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      typ_r <= in_req_type;
      node_r <= in_node_index;
      dest_r <= in_dest_index;
      cost_r <= (in_link_cost > INF) ? INF : in_link_cost;
      last_r <= in_last;
    end
    if (cmd.apply && ok && typ_r == dvrt_pkg::REQ_LOAD) begin
      nc_r[node_r] <= cost_r;
      nh_r[node_r] <= node_r;
    end
    if (cmd.apply && ok && typ_r == dvrt_pkg::REQ_COST) nc_r[node_r] <= cost_r;
    if (cmd.apply && ok && typ_r == dvrt_pkg::REQ_DOWN) nc_r[node_r] <= INF;
    if (cmd.rc_clr) begin
      best_r <= {1'b0, INF};
      hop_r <= '0;
      found_r <= 1'b0;
    end else if (cmd.rc_acc) begin
      if (nf_r[rdj_r] && (sum < best_r)) begin
        best_r <= sum;
        hop_r <= rdj_r;
        found_r <= 1'b1;
      end
    end
    if (cmd.rc_wr) begin
      if (nf_r[rdj_r] && (sum < best_r)) nh_r[cmd.ci] <= rdj_r;
      else if (found_r) nh_r[cmd.ci] <= hop_r;
      else if (nf_r[cmd.ci]) nh_r[cmd.ci] <= cmd.ci;
      else nh_r[cmd.ci] <= '0;
    end
    // result register
    if (cmd.ack) begin
      out_route_dest <= node_r;
      out_next_hop <= '0;
      out_has_next_hop <= 1'b0;
      out_path_cost <= '0;
      out_accepted <= ok && !sts.is_dump;
      out_last_result <= 1'b1;
    end else if (cmd.row) begin
      out_route_dest <= cmd.ci;
      out_next_hop <= rv_r[cmd.ci] ? nh_r[cmd.ci] : 3'd0;
      out_has_next_hop <= rv_r[cmd.ci];
      out_path_cost <= rd_r;
      out_accepted <= 1'b1;
      out_last_result <= cmd.lastr;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dvrt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dvrt_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       start,
  input wire       busy,
  input wire       out_valid,
  input wire       out_accepted,
  input wire       out_has_next_hop,
  input wire [2:0] out_next_hop
);
  `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `CHK_IMPL(a_beat_busy, clk, rst_n, out_valid, !$past(busy) == 1'b0)
  `CHK_IMPL(a_nh_zero, clk, rst_n, out_valid && !out_has_next_hop, out_next_hop == 3'd0)
  `CHK_IMPL(a_hop_acc, clk, rst_n, out_valid && out_has_next_hop, out_accepted)
endmodule
bind distance_vector_route_table_core dvrt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_accepted(out_accepted), .out_has_next_hop(out_has_next_hop),
  .out_next_hop(out_next_hop)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [15:0] INF = 16'hFFFF;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_req_type;
  logic [2:0]  in_node_index;
  logic [2:0]  in_dest_index;
  logic [15:0] in_link_cost;
  logic        in_last;
  logic        out_valid;
  logic [2:0]  out_route_dest;
  logic [2:0]  out_next_hop;
  logic        out_has_next_hop;
  logic [15:0] out_path_cost;
  logic        out_accepted;
  logic        out_last_result;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [3:0]  cfg_data;

  distance_vector_route_table_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_node_index(in_node_index),
    .in_dest_index(in_dest_index), .in_link_cost(in_link_cost), .in_last(in_last),
    .out_valid(out_valid), .out_route_dest(out_route_dest),
    .out_next_hop(out_next_hop), .out_has_next_hop(out_has_next_hop),
    .out_path_cost(out_path_cost), .out_accepted(out_accepted),
    .out_last_result(out_last_result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // One expected result beat: an acknowledgement or a dumped route row.
  typedef struct {
    logic [2:0]  dest;
    logic [2:0]  hop;
    logic        has_hop;
    logic [15:0] cost;
    logic        acc;
    logic        lst;
  } route_beat_t;

  route_beat_t pending_beats[$];
  int          fail_count;
  int          cycle_count;
  bit          idle_on;

  // Shadow copy of the router state.
  logic [15:0] dist_mat[64];
  logic [15:0] link_cost_tbl[8];
  logic        nbr_flag[8];
  logic [2:0]  hop_tbl[8];
  logic        hop_valid[8];
  logic        table_up;
  logic [2:0]  own_idx_reg;
  logic [3:0]  count_reg;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Global watchdog; a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int eff_n();
    int n;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > 8) n = 8;
    return n;
  endfunction

  function automatic int eff_me(int n);
    return (own_idx_reg >= n) ? n - 1 : own_idx_reg;
  endfunction

  // Bellman-Ford relaxation of the own row; first strictly smaller
  // neighbour wins, ties keep the lower index.
  task automatic route_recalc(int n, int me);
    logic [31:0] best, v;
    int hop;
    bit found;
    for (int i = 0; i < n; i++) begin
      if (i == me) continue;
      best = INF;
      hop = 0;
      found = 0;
      for (int j = 0; j < n; j++) begin
        if (nbr_flag[j]) begin
          v = link_cost_tbl[j] + dist_mat[j*8+i];
          if (v < best) begin
            best = v;
            hop = j;
            found = 1;
          end
        end
      end
      dist_mat[me*8+i] = best[15:0];
      if (found) begin
        hop_tbl[i] = 3'(hop);
        hop_valid[i] = 1'b1;
      end else if (nbr_flag[i]) begin
        // unreachable but directly attached: keep the route via itself
        hop_tbl[i] = 3'(i);
        hop_valid[i] = 1'b1;
      end else begin
        hop_tbl[i] = 3'd0;
        hop_valid[i] = 1'b0;
      end
    end
  endtask

  task automatic predict_request(logic [2:0] rt, logic [2:0] node, logic [2:0] dest,
                                 logic [15:0] cost, logic lst);
    int n, me;
    bit ok;
    route_beat_t b;
    n = eff_n();
    me = eff_me(n);
    ok = 0;
    if (rt == dvrt_pkg::REQ_DUMP && table_up) begin
      for (int k = 0; k < n; k++) begin
        b.dest = 3'(k);
        b.hop = hop_valid[k] ? hop_tbl[k] : 3'd0;
        b.has_hop = hop_valid[k];
        b.cost = dist_mat[me*8+k];
        b.acc = 1'b1;
        b.lst = (k + 1 == n);
        pending_beats.push_back(b);
      end
      return;
    end
    if (node < n) begin
      case (rt)
        dvrt_pkg::REQ_LOAD: if (!table_up) begin
          link_cost_tbl[node] = cost;
          nbr_flag[node] = (cost != 0 && cost < INF);
          hop_tbl[node] = node;
          hop_valid[node] = (cost < INF);
          if (lst) begin
            for (int i = 0; i < n; i++)
              for (int j = 0; j < n; j++)
                dist_mat[i*8+j] = (i == me) ? link_cost_tbl[j] : (i == j) ? 16'd0 : INF;
            route_recalc(n, me);
            table_up = 1'b1;
          end
          ok = 1;
        end
        dvrt_pkg::REQ_VEC: if (table_up && dest < n) begin
          dist_mat[node*8+dest] = cost;
          if (lst) route_recalc(n, me);
          ok = 1;
        end
        dvrt_pkg::REQ_COST: if (table_up) begin
          dist_mat[me*8+node] = cost;
          link_cost_tbl[node] = cost;
          route_recalc(n, me);
          ok = 1;
        end
        dvrt_pkg::REQ_DOWN: if (table_up) begin
          link_cost_tbl[node] = INF;
          nbr_flag[node] = 1'b0;
          route_recalc(n, me);
          ok = 1;
        end
        default: ;
      endcase
    end
    b.dest = node;
    b.hop = 3'd0;
    b.has_hop = 1'b0;
    b.cost = 16'd0;
    b.acc = ok;
    b.lst = 1'b1;
    pending_beats.push_back(b);
  endtask

  task automatic field_check(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result beats cannot be stalled: compare every out_valid beat here,
  // mid-cycle, where the registered outputs are settled.
  always @(negedge clk) begin
    route_beat_t b;
    if (rst_n && out_valid) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat, route_dest %0d", out_route_dest);
        fail_count++;
      end else begin
        b = pending_beats.pop_front();
        field_check("route_dest", b.dest, out_route_dest);
        field_check("next_hop", b.hop, out_next_hop);
        field_check("has_next_hop", b.has_hop, out_has_next_hop);
        field_check("path_cost", b.cost, out_path_cost);
        field_check("accepted", b.acc, out_accepted);
        field_check("last_result", b.lst, out_last_result);
      end
    end
  end

  // Send one request; returns at the edge after acceptance, with start low.
  task automatic send_req(logic [2:0] rt, logic [2:0] node, logic [2:0] dest,
                          logic [15:0] cost, logic lst);
    int gap;
    bit taken;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    repeat (gap) @(posedge clk);
    in_req_type <= rt;
    in_node_index <= node;
    in_dest_index <= dest;
    in_link_cost <= cost;
    in_last <= lst;
    start <= 1'b1;
    taken = 1'b0;
    // busy is stable mid-cycle; low there means the next edge takes the beat
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    predict_request(rt, node, dest, cost, lst);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes only with the block idle.
  task automatic write_reg(logic [0:0] idx, logic [3:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == dvrt_pkg::CFG_MY_INDEX) own_idx_reg = val[2:0];
    else count_reg = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_cost();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return INF;
      2: return 16'($urandom_range(1, 40));
      3: return 16'($urandom_range(1, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Requests other than loads before the table is built are ignored; so is
  // a load past the node count, last mark and all.
  task automatic test_before_ready();
    write_reg(dvrt_pkg::CFG_NODE_COUNT, 4'd2);
    send_req(dvrt_pkg::REQ_VEC, 3'd0, 3'd1, 16'd5, 1'b1);
    send_req(dvrt_pkg::REQ_COST, 3'd1, 3'd0, 16'd5, 1'b0);
    send_req(dvrt_pkg::REQ_DOWN, 3'd0, 3'd0, 16'd0, 1'b0);
    send_req(dvrt_pkg::REQ_DUMP, 3'd0, 3'd0, 16'd0, 1'b0);
    send_req(3'd5, 3'd0, 3'd0, 16'd0, 1'b0);
    send_req(3'd7, 3'd7, 3'd7, INF, 1'b1);
    send_req(dvrt_pkg::REQ_LOAD, 3'd1, 3'd0, 16'd9, 1'b0);
    send_req(dvrt_pkg::REQ_LOAD, 3'd7, 3'd0, 16'd3, 1'b1);
  endtask

  // Full eight-node load; last mark only after every cost is in.
  task automatic test_build_table();
    logic [15:0] c;
    write_reg(dvrt_pkg::CFG_NODE_COUNT, 4'd8);
    write_reg(dvrt_pkg::CFG_MY_INDEX, 4'd3);
    for (int k = 0; k < 8; k++) begin
      case (k)
        3: c = 16'd0;
        5: c = INF;
        6: c = 16'd65534;
        default: c = 16'($urandom_range(1, 30));
      endcase
      send_req(dvrt_pkg::REQ_LOAD, 3'(k), 3'd0, c, k == 7);
    end
    send_req(dvrt_pkg::REQ_LOAD, 3'd2, 3'd0, 16'd1, 1'b1);
    send_req(dvrt_pkg::REQ_DUMP, 3'd0, 3'd0, 16'd0, 1'b0);
  endtask

  task automatic test_directed_updates();
    send_req(dvrt_pkg::REQ_VEC, 3'd0, 3'd7, 16'd2, 1'b0);
    send_req(dvrt_pkg::REQ_VEC, 3'd3, 3'd1, 16'd1, 1'b0);   // own row entry
    send_req(dvrt_pkg::REQ_VEC, 3'd5, 3'd0, 16'd1, 1'b1);   // not a neighbour
    send_req(dvrt_pkg::REQ_VEC, 3'd1, 3'd7, INF, 1'b1);
    send_req(dvrt_pkg::REQ_COST, 3'd0, 3'd0, INF, 1'b0);
    send_req(dvrt_pkg::REQ_COST, 3'd5, 3'd0, 16'd4, 1'b0);
    send_req(dvrt_pkg::REQ_DOWN, 3'd1, 3'd0, 16'd0, 1'b0);
    send_req(dvrt_pkg::REQ_DOWN, 3'd7, 3'd0, 16'd0, 1'b0);
    send_req(3'd6, 3'd2, 3'd2, 16'd7, 1'b1);
    send_req(dvrt_pkg::REQ_DUMP, 3'd0, 3'd0, 16'd0, 1'b0);
  endtask

  task automatic rand_burst(int count);
    logic [2:0] rt;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: rt = dvrt_pkg::REQ_VEC;
        4, 5: rt = dvrt_pkg::REQ_COST;
        6: rt = dvrt_pkg::REQ_DOWN;
        7: rt = dvrt_pkg::REQ_DUMP;
        8: rt = dvrt_pkg::REQ_LOAD;
        default: rt = 3'($urandom_range(5, 7));
      endcase
      send_req(rt, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), rand_cost(),
               1'($urandom_range(0, 1)));
    end
    send_req(dvrt_pkg::REQ_DUMP, 3'd0, 3'd0, 16'd0, 1'b0);
  endtask

  // Random traffic across own-index and node-count settings; the effective
  // count never grows past the built size of eight (a setting of 15 clamps).
  task automatic test_random_updates();
    rand_burst(12);
    write_reg(dvrt_pkg::CFG_MY_INDEX, 4'd0);
    rand_burst(10);
    drain();   // sender holds off until every beat is back
    write_reg(dvrt_pkg::CFG_MY_INDEX, 4'hF);
    rand_burst(10);
    write_reg(dvrt_pkg::CFG_NODE_COUNT, 4'd3);   // own index clamps to 2
    rand_burst(8);
    write_reg(dvrt_pkg::CFG_NODE_COUNT, 4'd15);
    write_reg(dvrt_pkg::CFG_MY_INDEX, 4'd5);
    rand_burst(8);
  endtask

  task automatic test_small_count();
    write_reg(dvrt_pkg::CFG_NODE_COUNT, 4'd0);
    rand_burst(4);
    write_reg(dvrt_pkg::CFG_NODE_COUNT, 4'd1);
    idle_on = 0;
    rand_burst(4);
    write_reg(dvrt_pkg::CFG_NODE_COUNT, 4'd8);
    write_reg(dvrt_pkg::CFG_MY_INDEX, 4'd7);
    rand_burst(8);
  endtask

  initial begin
    fail_count = 0;
    cycle_count = 0;
    idle_on = 1;
    table_up = 1'b0;
    own_idx_reg = 3'd0;
    count_reg = 4'd1;
    for (int k = 0; k < 8; k++) begin
      nbr_flag[k] = 1'b0;
      hop_valid[k] = 1'b0;
      hop_tbl[k] = 3'd0;
      link_cost_tbl[k] = 16'd0;
    end
    for (int k = 0; k < 64; k++) dist_mat[k] = 16'd0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req_type <= dvrt_pkg::REQ_LOAD;
    in_node_index <= 3'd0;
    in_dest_index <= 3'd0;
    in_link_cost <= 16'd0;
    in_last <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= dvrt_pkg::CFG_MY_INDEX;
    cfg_data <= 4'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_ready();
    test_build_table();
    test_directed_updates();
    test_random_updates();
    test_small_count();

    drain();
    repeat (20) @(posedge clk);
    if (pending_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_beats.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
